// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Storage geometry
    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 8;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ENTRY_W  = KEY_BITS + TAG_BITS;

    // Port field widths
    localparam int CMD_W     = 3;
    localparam int KEY_IN_W  = 16;
    localparam int TAG_IN_W  = 8;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int PLACED_W  = 4;
    localparam int TAG_OUT_W = 8;
    localparam int KEY_OUT_W = 16;
    localparam int REMOVED_W = 5;
    localparam int SIZE_W    = 5;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ORDER_MODE = 1'b0;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_OFFER      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POLL       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_TAG = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [KEY_IN_W-1:0] entry_key;
        logic [TAG_IN_W-1:0] entry_tag;
        logic [POS_W-1:0]    position;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PLACED_W-1:0]  placed_at;
        logic [TAG_OUT_W-1:0] tag_out;
        logic [KEY_OUT_W-1:0] key_out;
        logic [REMOVED_W-1:0] removed_count;
        logic [SIZE_W-1:0]    queue_size;
    } rsp_t;

    // True when key a is served strictly before key b
    function automatic logic goes_before(input logic mode,
                                         input logic [KEY_BITS-1:0] a,
                                         input logic [KEY_BITS-1:0] b);
        goes_before = mode ? (a > b) : (a < b);
    endfunction

endpackage

`default_nettype wire

// ===== sv/spq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface spq_cmd_if import spq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [KEY_IN_W-1:0] entry_key;
    logic [TAG_IN_W-1:0] entry_tag;
    logic [POS_W-1:0]    position;

    modport source (output valid, command, entry_key, entry_tag, position, input ready);
    modport sink   (input valid, command, entry_key, entry_tag, position, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PLACED_W-1:0]  placed_at;
    logic [TAG_OUT_W-1:0] tag_out;
    logic [KEY_OUT_W-1:0] key_out;
    logic [REMOVED_W-1:0] removed_count;
    logic [SIZE_W-1:0]    queue_size;

    modport source (output valid, status, placed_at, tag_out, key_out, removed_count,
                    queue_size, input ready);
    modport sink   (input valid, status, placed_at, tag_out, key_out, removed_count,
                    queue_size, output ready);
endinterface

`default_nettype wire

// ===== sv/spq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 24,
    parameter int WORDS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(WORDS)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(WORDS)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/spq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl import spq_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic order_mode,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    input  wire logic out_free,
    output logic      rsp_load,
    output rsp_t      rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_TAIL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]     op_reg, op_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic [CNT_W-1:0]     wr_idx_reg, wr_idx_next;
    logic                 found_reg, found_next;
    logic [KEY_BITS-1:0]  carry_key_reg, carry_key_next;
    logic [TAG_BITS-1:0]  carry_tag_reg, carry_tag_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [IDX_W-1:0]     placed_reg, placed_next;
    logic [KEY_BITS-1:0]  key_o_reg, key_o_next;
    logic [TAG_BITS-1:0]  tag_o_reg, tag_o_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [ENTRY_W-1:0]   wdata;
    logic [ENTRY_W-1:0]   rdata;
    logic [KEY_BITS-1:0]  rd_key;
    logic [TAG_BITS-1:0]  rd_tag;

    assign rd_key = rdata[ENTRY_W-1:TAG_BITS];
    assign rd_tag = rdata[TAG_BITS-1:0];

    spq_ram #(
        .WIDTH (ENTRY_W),
        .WORDS (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        tag_next       = tag_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        wr_idx_next    = wr_idx_reg;
        found_next     = found_reg;
        carry_key_next = carry_key_reg;
        carry_tag_next = carry_tag_reg;
        status_next    = status_reg;
        placed_next    = placed_reg;
        key_o_next     = key_o_reg;
        tag_o_next     = tag_o_reg;
        removed_next   = removed_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = {carry_key_reg, carry_tag_reg};
        rsp_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next        = cmd.command;
                    key_next       = cmd.entry_key[KEY_BITS-1:0];
                    tag_next       = cmd.entry_tag[TAG_BITS-1:0];
                    pos_next       = IDX_W'(cmd.position);
                    carry_key_next = cmd.entry_key[KEY_BITS-1:0];
                    carry_tag_next = cmd.entry_tag[TAG_BITS-1:0];
                    rd_idx_next    = '0;
                    wr_idx_next    = '0;
                    found_next     = 1'b0;
                    status_next    = ST_OK;
                    placed_next    = '0;
                    key_o_next     = '0;
                    tag_o_next     = '0;
                    removed_next   = '0;
                    state_next     = S_DONE;
                    priority if (cmd.command == CMD_OFFER)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                            status_next = ST_FULL;
                        else if (count_reg == '0)
                            state_next = S_TAIL;
                        else
                            state_next = S_SCAN;
                    end
                    else if (cmd.command == CMD_POLL || cmd.command == CMD_PEEK)
                    begin
                        pos_next = '0;
                        if (count_reg == '0)
                            status_next = ST_EMPTY;
                        else
                            state_next = S_SCAN;
                    end
                    else if (cmd.command == CMD_READ_AT || cmd.command == CMD_REMOVE_AT)
                    begin
                        if (CNT_W'(cmd.position) >= count_reg)
                            status_next = ST_EMPTY;
                        else
                            state_next = S_SCAN;
                    end
                    else if (cmd.command == CMD_REMOVE_TAG)
                    begin
                        if (count_reg != '0)
                            state_next = S_SCAN;
                    end
                    else
                    begin
                        // unused codes: plain result, status ok
                    end
                end
            end

            S_SCAN:
            begin
                // issue next read
                if (rd_idx_reg < count_reg)
                begin
                    pend_next   = 1'b1;
                    pidx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                // process entry read last cycle
                if (pend_reg)
                begin
                    priority if (op_reg == CMD_OFFER)
                    begin
                        if (found_reg || goes_before(order_mode, key_reg, rd_key))
                        begin
                            we             = 1'b1;
                            waddr          = pidx_reg;
                            carry_key_next = rd_key;
                            carry_tag_next = rd_tag;
                            if (!found_reg)
                            begin
                                found_next  = 1'b1;
                                placed_next = pidx_reg;
                            end
                        end
                    end
                    else if (op_reg == CMD_PEEK || op_reg == CMD_READ_AT)
                    begin
                        if (pidx_reg == pos_reg)
                        begin
                            key_o_next = rd_key;
                            tag_o_next = rd_tag;
                        end
                    end
                    else if (op_reg == CMD_POLL || op_reg == CMD_REMOVE_AT)
                    begin
                        if (pidx_reg == pos_reg)
                        begin
                            key_o_next = rd_key;
                            tag_o_next = rd_tag;
                        end
                        else
                        begin
                            we          = 1'b1;
                            waddr       = wr_idx_reg[IDX_W-1:0];
                            wdata       = rdata;
                            wr_idx_next = wr_idx_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (rd_tag == tag_reg)
                        begin
                            removed_next = removed_reg + CNT_W'(1);
                        end
                        else
                        begin
                            we          = 1'b1;
                            waddr       = wr_idx_reg[IDX_W-1:0];
                            wdata       = rdata;
                            wr_idx_next = wr_idx_reg + CNT_W'(1);
                        end
                    end

                    // last entry handled
                    if (rd_idx_reg == count_reg)
                    begin
                        priority if (op_reg == CMD_OFFER)
                            state_next = S_TAIL;
                        else if (op_reg == CMD_POLL || op_reg == CMD_REMOVE_AT)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_DONE;
                        end
                        else if (op_reg == CMD_REMOVE_TAG)
                        begin
                            count_next = wr_idx_next;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_DONE;
                    end
                end
            end

            S_TAIL:
            begin
                // carry lands in the slot past the old end
                we         = 1'b1;
                waddr      = count_reg[IDX_W-1:0];
                count_next = count_reg + CNT_W'(1);
                if (!found_reg)
                    placed_next = count_reg[IDX_W-1:0];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp.status        = status_reg;
        rsp.placed_at     = PLACED_W'(placed_reg);
        rsp.tag_out       = TAG_OUT_W'(tag_o_reg);
        rsp.key_out       = KEY_OUT_W'(key_o_reg);
        rsp.removed_count = REMOVED_W'(removed_reg);
        rsp.queue_size    = SIZE_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        tag_reg       <= tag_next;
        pos_reg       <= pos_next;
        rd_idx_reg    <= rd_idx_next;
        pidx_reg      <= pidx_next;
        wr_idx_reg    <= wr_idx_next;
        found_reg     <= found_next;
        carry_key_reg <= carry_key_next;
        carry_tag_reg <= carry_tag_next;
        status_reg    <= status_next;
        placed_reg    <= placed_next;
        key_o_reg     <= key_o_next;
        tag_o_reg     <= tag_o_next;
        removed_reg   <= removed_next;
    end

endmodule

`default_nettype wire

// ===== sv/sorted_priority_queue_unit.sv =====
// Sorted priority queue of up to 16 entries (16-bit key, 8-bit tag).
// Command words come in on cmd_in (valid/ready): offer, poll, peek,
// read at, remove by tag, remove at. Each command yields exactly one
// result word on rsp_out (valid/ready) carrying status, placed_at,
// tag_out, key_out, removed_count and queue_size.
// order_mode (APB register 0, bit 0): 0 serves smallest key first,
// 1 serves largest key first. Write it only while the queue is idle.
// A command that scans reads the held entries one per cycle from the
// simple dual-port entry RAM; an offer then adds a tail write. A
// rejected command or one on an empty queue goes straight to the
// result, and an offer into an empty queue does only the tail write.
// One command is worked on at a time; the next is accepted as soon as
// the previous result has been handed to the output register.
// Reset empties the queue and clears order_mode; RAM contents are not
// cleared (slots past the fill count are never read).
// If the receiver stalls, the result waits in the output register; the
// next command may be accepted and worked, and its result holds until
// the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit import spq_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    spq_cmd_if.sink                 cmd_in,
    spq_rsp_if.source               rsp_out
);

    logic order_mode_reg;
    logic cfg_hit;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_engine;
    cmd_t cmd_word;
    logic out_free;
    logic rsp_load;
    logic cmd_ready;

    // APB: register index sits at paddr[2], low two bits are byte offset
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1] == REG_ORDER_MODE);
    assign prdata  = cfg_hit ? PDATA_W'(order_mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_mode_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && cfg_hit)
            order_mode_reg <= pwdata[0];
    end

    assign cmd_word.command   = cmd_in.command;
    assign cmd_word.entry_key = cmd_in.entry_key;
    assign cmd_word.entry_tag = cmd_in.entry_tag;
    assign cmd_word.position  = cmd_in.position;
    assign cmd_in.ready       = cmd_ready;

    // output register frees when empty or being taken this cycle
    assign out_free = !rsp_valid_reg || rsp_out.ready;

    spq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .order_mode (order_mode_reg),
        .cmd_valid  (cmd_in.valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd_word),
        .out_free   (out_free),
        .rsp_load   (rsp_load),
        .rsp        (rsp_engine)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp_out.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
            rsp_reg <= rsp_engine;
    end

    assign rsp_out.valid         = rsp_valid_reg;
    assign rsp_out.status        = rsp_reg.status;
    assign rsp_out.placed_at     = rsp_reg.placed_at;
    assign rsp_out.tag_out       = rsp_reg.tag_out;
    assign rsp_out.key_out       = rsp_reg.key_out;
    assign rsp_out.removed_count = rsp_reg.removed_count;
    assign rsp_out.queue_size    = rsp_reg.queue_size;

endmodule

`default_nettype wire
